### src/wtsq_pkg.sv
// Package for the wrapping timeout sleep queue.
// Holds the opcode and status codes and the control structs between top and cells.
// No dependencies.
package wtsq_pkg;

	localparam int OP_W   = 2;
	localparam int TASK_W = 4;
	localparam int ST_W   = 2;

	typedef enum logic [OP_W-1:0] {
		OP_INSERT = 2'd0,
		OP_REMOVE = 2'd1,
		OP_PEEK   = 2'd2,
		OP_NONE   = 2'd3
	} opcode_t;

	typedef enum logic [ST_W-1:0] {
		ST_OK     = 2'd0,
		ST_FULL   = 2'd1,
		ST_ABSENT = 2'd2,
		ST_DUP    = 2'd3
	} status_t;

	// Broadcast from the top level to every cell.
	typedef struct packed {
		logic capture;  // register the per-cell match and order compare
		logic do_ins;   // commit an insert this cycle
		logic do_rm;    // commit a remove this cycle
	} cell_ctl_t;

	// Passed from each cell to its right-hand neighbor.
	typedef struct packed {
		logic seen;     // the insert point lies at or left of this boundary
		logic rm;       // the removed entry lies at or left of this boundary
	} chain_t;

endpackage

### src/wtsq_cell.sv
// One slot of the sorted sleep chain: a task number, its wake time and two compare flags.
// Depends on wtsq_pkg. Instantiated in a row by wrapping_timeout_sleep_queue_top.
module wtsq_cell import wtsq_pkg::*; #(
	parameter int TICK_BITS = 32
) (
	input  logic                 clk,
	input  cell_ctl_t            ctl,
	input  logic                 valid,
	input  logic [TASK_W-1:0]    id_new,
	input  logic [TICK_BITS-1:0] wake_new,
	input  logic [TICK_BITS-1:0] now_tick,
	input  logic [TICK_BITS-1:0] key_new,
	input  chain_t               chain_in,
	output chain_t               chain_out,
	input  logic [TASK_W-1:0]    left_task,
	input  logic [TICK_BITS-1:0] left_wake,
	input  logic [TASK_W-1:0]    right_task,
	input  logic [TICK_BITS-1:0] right_wake,
	output logic [TASK_W-1:0]    task_q,
	output logic [TICK_BITS-1:0] wake_q,
	output logic                 match_s2,
	output logic                 ins_here
);

	logic [TICK_BITS-1:0] key_slot;
	logic                 ge_s2;
	logic                 stop;

	// Time remaining before wake; a wake at or below now wraps to the far end.
	assign key_slot = wake_q - now_tick - TICK_BITS'(1);

	always_ff @(posedge clk) begin
		if (ctl.capture) begin
			match_s2 <= valid && (task_q == id_new);
			ge_s2    <= key_slot >= key_new;
		end
	end

	// An empty slot always stops the insert search, so the first free slot catches it.
	assign stop      = valid ? ge_s2 : 1'b1;
	assign ins_here  = !chain_in.seen && stop;
	assign chain_out = '{seen: chain_in.seen || stop, rm: chain_in.rm || match_s2};

	always_ff @(posedge clk) begin
		if (ctl.do_ins) begin
			if (chain_in.seen) begin
				task_q <= left_task;
				wake_q <= left_wake;
			end else if (ins_here) begin
				task_q <= id_new;
				wake_q <= wake_new;
			end
		end else if (ctl.do_rm && chain_out.rm) begin
			task_q <= right_task;
			wake_q <= right_wake;
		end
	end

endmodule

### src/wrapping_timeout_sleep_queue_top.sv
// Top level of the wrapping timeout sleep queue: command port, stage control and the cell row.
// Depends on wtsq_pkg and wtsq_cell.
//
//  channel   handshake            payload
//  command   start / busy         opcode, task_id, wake_time, now_tick
//  result    done (one cycle)     head_task, head_wake, queue_empty, op_status
//
// Each command runs in three steps: capture, per-cell compare in every slot at once, then
// a single shift of the cell row. The compare of each slot's remaining time sets the middle cycle.
// busy is high after a transfer until the commit; the result strobe follows with busy low,
// so a new command is not taken before the previous one commits, but can be taken with its result strobe.
// Reset empties the queue; slot contents are not cleared. The receiver cannot stall results.
module wrapping_timeout_sleep_queue_top import wtsq_pkg::*; #(
	parameter int MAX_TASKS = 16,
	parameter int TICK_BITS = 32
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	output logic                 busy,
	input  logic [OP_W-1:0]      opcode,
	input  logic [TASK_W-1:0]    task_id,
	input  logic [TICK_BITS-1:0] wake_time,
	input  logic [TICK_BITS-1:0] now_tick,
	output logic                 done,
	output logic [TASK_W-1:0]    head_task,
	output logic [TICK_BITS-1:0] head_wake,
	output logic                 queue_empty,
	output logic [ST_W-1:0]      op_status
);

	localparam int CNT_W = $clog2(MAX_TASKS + 1);

	logic                 vld_s1, vld_s2;
	logic [OP_W-1:0]      op_s1;
	logic [TASK_W-1:0]    id_s1;
	logic [TICK_BITS-1:0] wake_s1, now_s1;
	logic [CNT_W-1:0]     count_q, count_next;

	cell_ctl_t            ctl;
	chain_t               chain [MAX_TASKS+1];
	logic [TASK_W-1:0]    c_task [MAX_TASKS];
	logic [TICK_BITS-1:0] c_wake [MAX_TASKS];
	logic [MAX_TASKS-1:0] c_match, c_ins, c_valid;
	logic [TICK_BITS-1:0] key_new;

	logic                 is_ins, is_rm, found, full;
	status_t              status;
	logic [TASK_W-1:0]    nhead_task;
	logic [TICK_BITS-1:0] nhead_wake;

	logic                 done_q, empty_q;
	logic [TASK_W-1:0]    head_task_q;
	logic [TICK_BITS-1:0] head_wake_q;
	logic [ST_W-1:0]      status_q;

	assign busy = vld_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1  <= 1'b0;
			vld_s2  <= 1'b0;
			done_q  <= 1'b0;
			count_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start && !busy) begin
				vld_s1 <= 1'b1;
			end else if (vld_s2) begin
				vld_s1  <= 1'b0;
				vld_s2  <= 1'b0;
				done_q  <= 1'b1;
				count_q <= count_next;
			end else if (vld_s1) begin
				vld_s2 <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start && !busy) begin
			op_s1   <= opcode;
			id_s1   <= task_id;
			wake_s1 <= wake_time;
			now_s1  <= now_tick;
		end
	end

	assign key_new = wake_s1 - now_s1 - TICK_BITS'(1);

	always_comb begin
		is_ins = (op_s1 == OP_INSERT);
		is_rm  = (op_s1 == OP_REMOVE);
		found  = |c_match;
		full   = (count_q == CNT_W'(MAX_TASKS));
		status = ST_OK;
		if (is_ins && found) begin
			status = ST_DUP;
		end else if (is_ins && full) begin
			status = ST_FULL;
		end else if (is_rm && !found) begin
			status = ST_ABSENT;
		end
		ctl.capture = vld_s1 && !vld_s2;
		ctl.do_ins  = vld_s2 && is_ins && !found && !full;
		ctl.do_rm   = vld_s2 && is_rm && found;
		count_next  = count_q;
		if (ctl.do_ins) begin
			count_next = count_q + CNT_W'(1);
		end else if (ctl.do_rm) begin
			count_next = count_q - CNT_W'(1);
		end
		// Head after the commit, taken from what the first cell is about to load.
		if (ctl.do_ins && c_ins[0]) begin
			nhead_task = id_s1;
			nhead_wake = wake_s1;
		end else if (ctl.do_rm && c_match[0]) begin
			nhead_task = c_task[1];
			nhead_wake = c_wake[1];
		end else begin
			nhead_task = c_task[0];
			nhead_wake = c_wake[0];
		end
	end

	assign chain[0] = '{seen: 1'b0, rm: 1'b0};

	for (genvar i = 0; i < MAX_TASKS; i++) begin : g_cell
		localparam int L = (i == 0) ? 0 : i - 1;
		localparam int R = (i == MAX_TASKS - 1) ? i : i + 1;
		assign c_valid[i] = CNT_W'(i) < count_q;
		wtsq_cell #(
			.TICK_BITS(TICK_BITS)
		) u_cell (
			.clk       (clk),
			.ctl       (ctl),
			.valid     (c_valid[i]),
			.id_new    (id_s1),
			.wake_new  (wake_s1),
			.now_tick  (now_s1),
			.key_new   (key_new),
			.chain_in  (chain[i]),
			.chain_out (chain[i+1]),
			.left_task (c_task[L]),
			.left_wake (c_wake[L]),
			.right_task(c_task[R]),
			.right_wake(c_wake[R]),
			.task_q    (c_task[i]),
			.wake_q    (c_wake[i]),
			.match_s2  (c_match[i]),
			.ins_here  (c_ins[i])
		);
	end

	always_ff @(posedge clk) begin
		if (vld_s2) begin
			empty_q     <= (count_next == '0);
			head_task_q <= (count_next == '0) ? '0 : nhead_task;
			head_wake_q <= (count_next == '0) ? '0 : nhead_wake;
			status_q    <= status;
		end
	end

	assign done        = done_q;
	assign head_task   = head_task_q;
	assign head_wake   = head_wake_q;
	assign queue_empty = empty_q;
	assign op_status   = status_q;

	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(MAX_TASKS))
		else $error("queue count exceeds slot count");

	a_single_match: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s2 |-> $onehot0(c_match))
		else $error("task number held in more than one slot");

	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> !vld_s1 && !vld_s2)
		else $error("result strobe while a command is still in flight");

	a_count_step: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.do_ins |=> count_q == $past(count_q) + CNT_W'(1))
		else $error("insert did not grow the queue by one");

endmodule

### dv/tb_wrapping_timeout_sleep_queue_top.sv
// Testbench for the wrapping timeout sleep queue: directed and random commands, checked
// against a predictor of the sorted queue that runs on each command transfer.
// Depends on wtsq_pkg and wrapping_timeout_sleep_queue_top.
`timescale 1ns / 1ps

module tb_wrapping_timeout_sleep_queue_top;
	import wtsq_pkg::*;

	localparam int MAX_TASKS = 16;
	localparam int TICK_BITS = 32;
	localparam int STALL_LIMIT = 1000;

	typedef struct {
		logic [TASK_W-1:0]    head_task;
		logic [TICK_BITS-1:0] head_wake;
		logic                 queue_empty;
		status_t              op_status;
	} head_rec_t;

	logic                 clk = 1'b0;
	logic                 arst_n;
	logic                 start;
	logic                 busy;
	logic [OP_W-1:0]      opcode;
	logic [TASK_W-1:0]    task_id;
	logic [TICK_BITS-1:0] wake_time;
	logic [TICK_BITS-1:0] now_tick;
	logic                 done;
	logic [TASK_W-1:0]    head_task;
	logic [TICK_BITS-1:0] head_wake;
	logic                 queue_empty;
	logic [ST_W-1:0]      op_status;

	// Predicted queue contents, head first.
	logic [TASK_W-1:0]    sleep_task[MAX_TASKS];
	logic [TICK_BITS-1:0] sleep_wake[MAX_TASKS];
	int                   sleep_count;

	head_rec_t            head_expect_q[$];
	int                   err_count;
	int                   idle_pct;
	int                   stall_cycles;
	logic [TICK_BITS-1:0] cur_now;

	wrapping_timeout_sleep_queue_top #(
		.MAX_TASKS(MAX_TASKS),
		.TICK_BITS(TICK_BITS)
	) i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.opcode(opcode),
		.task_id(task_id),
		.wake_time(wake_time),
		.now_tick(now_tick),
		.done(done),
		.head_task(head_task),
		.head_wake(head_wake),
		.queue_empty(queue_empty),
		.op_status(op_status)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	function automatic logic [TICK_BITS-1:0] time_left(logic [TICK_BITS-1:0] wake,
			logic [TICK_BITS-1:0] now);
		return wake - now - 1'b1;
	endfunction

	function automatic int slot_of(logic [TASK_W-1:0] id);
		for (int i = 0; i < sleep_count; i++) begin
			if (sleep_task[i] == id)
				return i;
		end
		return -1;
	endfunction

	// Applies one command to the predicted queue and records the head it should report.
	task automatic sleep_q_step(opcode_t op, logic [TASK_W-1:0] id,
			logic [TICK_BITS-1:0] wake, logic [TICK_BITS-1:0] now);
		int                   pos;
		int                   at;
		logic [TICK_BITS-1:0] k;
		status_t              st;
		head_rec_t            rec;
		st = ST_OK;
		pos = slot_of(id);
		case (op)
			OP_INSERT: begin
				if (pos >= 0) begin
					st = ST_DUP;
				end else if (sleep_count >= MAX_TASKS) begin
					st = ST_FULL;
				end else begin
					// The new task goes ahead of the first entry whose key is not smaller.
					k = time_left(wake, now);
					at = sleep_count;
					for (int i = sleep_count - 1; i >= 0; i--) begin
						if (time_left(sleep_wake[i], now) >= k)
							at = i;
					end
					for (int i = sleep_count; i > at; i--) begin
						sleep_task[i] = sleep_task[i-1];
						sleep_wake[i] = sleep_wake[i-1];
					end
					sleep_task[at] = id;
					sleep_wake[at] = wake;
					sleep_count++;
				end
			end
			OP_REMOVE: begin
				if (pos < 0) begin
					st = ST_ABSENT;
				end else begin
					for (int i = pos; i + 1 < sleep_count; i++) begin
						sleep_task[i] = sleep_task[i+1];
						sleep_wake[i] = sleep_wake[i+1];
					end
					sleep_count--;
				end
			end
			default: ;
		endcase
		if (sleep_count == 0) begin
			rec.head_task = '0;
			rec.head_wake = '0;
			rec.queue_empty = 1'b1;
		end else begin
			rec.head_task = sleep_task[0];
			rec.head_wake = sleep_wake[0];
			rec.queue_empty = 1'b0;
		end
		rec.op_status = st;
		head_expect_q.push_back(rec);
	endtask

	// Sends one command. start is left high after the transfer so that a following
	// command can go out back to back.
	task automatic send_cmd(opcode_t op, logic [TASK_W-1:0] id,
			logic [TICK_BITS-1:0] wake, logic [TICK_BITS-1:0] now);
		while ($urandom_range(99) < idle_pct) begin
			start <= 1'b0;
			@(posedge clk);
		end
		start <= 1'b1;
		opcode <= op;
		task_id <= id;
		wake_time <= wake;
		now_tick <= now;
		do
			@(posedge clk);
		while (busy);
		sleep_q_step(op, id, wake, now);
	endtask

	function automatic logic [TASK_W-1:0] pick_task(bit queued);
		logic [TASK_W-1:0] id;
		do
			id = TASK_W'($urandom_range(MAX_TASKS - 1));
		while ((slot_of(id) >= 0) != queued);
		return id;
	endfunction

	// Wake times cluster around the current tick, with keys at both ends of the range,
	// ties with queued entries and fully random values mixed in.
	function automatic logic [TICK_BITS-1:0] pick_wake();
		case ($urandom_range(7))
			0: return cur_now;
			1: return cur_now + 1'b1;
			2: return $urandom;
			3: return cur_now - $urandom_range(1, 50);
			4: return (sleep_count > 0) ? sleep_wake[$urandom_range(sleep_count - 1)] :
				cur_now + 2'd2;
			default: return cur_now + $urandom_range(2, 200);
		endcase
	endfunction

	function automatic logic [TICK_BITS-1:0] pick_now();
		if ($urandom_range(19) == 0)
			return $urandom;
		cur_now = cur_now + $urandom_range(0, 20);
		return cur_now;
	endfunction

	task automatic test_empty_queue();
		send_cmd(OP_PEEK, 4'd9, 32'h1234_5678, 32'h0);
		send_cmd(OP_NONE, 4'd6, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
		send_cmd(OP_REMOVE, 4'd5, 32'h0, 32'h0);
	endtask

	task automatic test_sole_head();
		send_cmd(OP_INSERT, 4'd0, 32'h0, 32'hFFFF_FFFF);
		send_cmd(OP_REMOVE, 4'd0, 32'h0, 32'hFFFF_FFFF);
		send_cmd(OP_PEEK, 4'd0, 32'h0, 32'h0);
	endtask

	task automatic test_ordering();
		send_cmd(OP_INSERT, 4'd15, 32'hFFFF_FFFF, 32'h0);
		// A wake time equal to now has the largest key and goes last.
		send_cmd(OP_INSERT, 4'd3, 32'd100, 32'd100);
		// One tick ahead is the smallest key and becomes the head.
		send_cmd(OP_INSERT, 4'd4, 32'd101, 32'd100);
		// Same key as task 3, so it goes in front of it.
		send_cmd(OP_INSERT, 4'd10, 32'd100, 32'd100);
		send_cmd(OP_INSERT, 4'd15, 32'd5, 32'd100);
		send_cmd(OP_REMOVE, 4'd4, 32'h0, 32'd100);
		send_cmd(OP_REMOVE, 4'd10, 32'h0, 32'd100);
		send_cmd(OP_REMOVE, 4'd15, 32'h0, 32'd100);
		send_cmd(OP_REMOVE, 4'd3, 32'h0, 32'd100);
		send_cmd(OP_REMOVE, 4'd3, 32'h0, 32'd100);
	endtask

	// Random sequences: fill bursts up to a full queue, drain bursts that stop at empty,
	// sweeps across the tick wrap and single noisy commands. With sixteen task numbers
	// and sixteen slots, an insert into a full queue is always a duplicate.
	task automatic test_random(int n_items);
		int sent;
		int burst;
		sent = 0;
		while (sent < n_items) begin
			case ($urandom_range(9))
				0, 1, 2, 3: begin
					send_cmd(opcode_t'($urandom_range(3)),
						TASK_W'($urandom_range(MAX_TASKS - 1)), pick_wake(), pick_now());
					sent++;
				end
				4, 5: begin
					while (sleep_count < MAX_TASKS && sent < n_items) begin
						send_cmd(OP_INSERT, pick_task(1'b0), pick_wake(), pick_now());
						sent++;
					end
					send_cmd(OP_INSERT, TASK_W'($urandom_range(MAX_TASKS - 1)), pick_wake(),
						pick_now());
					sent++;
				end
				6, 7: begin
					burst = $urandom_range(1, MAX_TASKS);
					while (sleep_count > 0 && burst > 0 && sent < n_items) begin
						send_cmd(OP_REMOVE, pick_task(1'b1), $urandom, pick_now());
						sent++;
						burst--;
					end
				end
				8: begin
					cur_now = {TICK_BITS{1'b1}} - $urandom_range(0, 40);
					for (int i = 0; i < 6 && sent < n_items; i++) begin
						if (sleep_count < MAX_TASKS)
							send_cmd(OP_INSERT, pick_task(1'b0), pick_wake(), pick_now());
						else
							send_cmd(OP_REMOVE, pick_task(1'b1), $urandom, pick_now());
						sent++;
					end
				end
				default: begin
					send_cmd($urandom_range(1) ? OP_PEEK : OP_NONE,
						TASK_W'($urandom_range(MAX_TASKS - 1)), $urandom, pick_now());
					sent++;
				end
			endcase
		end
	endtask

	always @(posedge clk) begin
		head_rec_t rec;
		if (done) begin
			if (head_expect_q.size() == 0) begin
				$display("%0t: result with none expected: task %0d wake %h empty %b status %0d",
					$time, head_task, head_wake, queue_empty, op_status);
				err_count++;
			end else begin
				rec = head_expect_q.pop_front();
				if (head_task !== rec.head_task) begin
					$display("%0t: head_task expected %0d actual %0d",
						$time, rec.head_task, head_task);
					err_count++;
				end
				if (head_wake !== rec.head_wake) begin
					$display("%0t: head_wake expected %h actual %h",
						$time, rec.head_wake, head_wake);
					err_count++;
				end
				if (queue_empty !== rec.queue_empty) begin
					$display("%0t: queue_empty expected %b actual %b",
						$time, rec.queue_empty, queue_empty);
					err_count++;
				end
				if (op_status !== rec.op_status) begin
					$display("%0t: op_status expected %0d actual %0d",
						$time, rec.op_status, op_status);
					err_count++;
				end
			end
		end
	end

	// Ends the run when neither a command nor a result is transferred for too long.
	always @(posedge clk) begin
		if (!arst_n || done || (start && !busy)) begin
			stall_cycles <= 0;
		end else if (stall_cycles >= STALL_LIMIT) begin
			$display("tb_wrapping_timeout_sleep_queue_top: done, errors");
			$finish;
		end else begin
			stall_cycles <= stall_cycles + 1;
		end
	end

	initial begin
		err_count = 0;
		stall_cycles = 0;
		sleep_count = 0;
		cur_now = $urandom;
		arst_n = 1'b0;
		start <= 1'b0;
		opcode <= OP_PEEK;
		task_id <= '0;
		wake_time <= '0;
		now_tick <= '0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		idle_pct = 8;
		test_empty_queue();
		test_sole_head();
		test_ordering();
		test_random(550);
		idle_pct = 48;
		test_random(550);
		idle_pct = 0;
		test_random(550);

		@(posedge clk);
		start <= 1'b0;
		while (head_expect_q.size() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);
		if (err_count == 0)
			$display("tb_wrapping_timeout_sleep_queue_top: done, clean");
		else
			$display("tb_wrapping_timeout_sleep_queue_top: done, errors");
		$finish;
	end

endmodule

### wrapping_timeout_sleep_queue_top.f
src/wtsq_pkg.sv
src/wtsq_cell.sv
src/wrapping_timeout_sleep_queue_top.sv
dv/tb_wrapping_timeout_sleep_queue_top.sv
